// File: design/tdts_pkg.sv
// ----------------------------------------------------------------------------
// tdts_pkg
// Shared types and constants for the tick-driven task selector.
// ----------------------------------------------------------------------------
package tdts_pkg;

    localparam int unsigned REQ_W   = 2;
    localparam int unsigned TASK_W  = 4;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned PRIO_W  = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SCHED = 2'd2;

    // policy register values
    localparam logic POLICY_SHORTEST = 1'b0;
    localparam logic POLICY_PRIORITY = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TASK_W-1:0] task_index;
        logic [CNT_W-1:0]  count_value;
        logic [PRIO_W-1:0] priority_value;
    } t_in_item;

    typedef struct packed {
        logic [TASK_W-1:0] running_task;
        logic              switched;
        logic              exhausted;
        logic [CNT_W-1:0]  running_count;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

// File: design/tdts_task_mem.sv
// ----------------------------------------------------------------------------
// tdts_task_mem
// Task table: remaining-count and priority memories with per-entry valid
// bits. An entry never loaded since reset reads as zero.
// ----------------------------------------------------------------------------
module tdts_task_mem #(
    parameter int unsigned NUM_TASKS  = 16,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_cnt_en,
    input  logic                          i_wr_prio_en,
    input  logic [$clog2(NUM_TASKS)-1:0]  i_wr_addr,
    input  logic [COUNT_BITS-1:0]         i_wr_cnt,
    input  logic [tdts_pkg::PRIO_W-1:0]   i_wr_prio,
    input  logic [$clog2(NUM_TASKS)-1:0]  i_rd_addr,
    output logic [COUNT_BITS-1:0]         o_rd_cnt,
    output logic [tdts_pkg::PRIO_W-1:0]   o_rd_prio
);

    logic [COUNT_BITS-1:0]       r_cnt_mem  [NUM_TASKS];
    logic [tdts_pkg::PRIO_W-1:0] r_prio_mem [NUM_TASKS];
    logic [NUM_TASKS-1:0]        r_valid;

    logic [COUNT_BITS-1:0]       r_rd_cnt;
    logic [tdts_pkg::PRIO_W-1:0] r_rd_prio;
    logic                        r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt_en) begin
            r_cnt_mem[i_wr_addr] <= i_wr_cnt;
        end
        r_rd_cnt <= r_cnt_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_prio_en) begin
            r_prio_mem[i_wr_addr] <= i_wr_prio;
        end
        r_rd_prio <= r_prio_mem[i_rd_addr];
    end

    // a load writes both halves, so the priority write marks the entry live
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_prio_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_cnt  = r_rd_vld ? r_rd_cnt  : '0;
    assign o_rd_prio = r_rd_vld ? r_rd_prio : '0;

endmodule

// File: design/tick_driven_task_selector_top.sv
// ----------------------------------------------------------------------------
// tick_driven_task_selector_top
// Shortest-remaining / highest-priority task selector driven by tick items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries tick, load and
//   schedule requests. Each request yields one result on the output channel
//   (o_out_valid / i_out_ready / o_out_data) with the running task, its count
//   and switched / exhausted flags. i_cfg_wr_en / i_cfg_wr_data set the policy
//   (0 shortest count, 1 highest priority); write it only while idle.
//   Load items and ticks that need no reselection pass through the execute
//   and final states. Items that run a selection also pass through the scan,
//   which reads task entries 1..NUM_TASKS-1 one per cycle, and a drain state
//   for the registered table read. One item is in flight at a time; a new
//   input transfer is taken only after the result is loaded into the output
//   register. o_in_ready is high while the sequencer is idle, also while an
//   earlier result still waits in the output register.
//   If the receiver stalls, a finished item holds in the final state until
//   the output register frees up.
//   Reset clears all task entries (valid bits), selects the idle task and sets
//   shortest-count policy. No clearing pass is needed.
// ----------------------------------------------------------------------------
module tick_driven_task_selector_top #(
    parameter int unsigned NUM_TASKS  = 16,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tdts_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tdts_pkg::t_out_item o_out_data,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data
);

    localparam int unsigned IDX_W = $clog2(NUM_TASKS);

    tdts_pkg::t_state    r_state, n_state;
    tdts_pkg::t_in_item  r_req;
    tdts_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic                r_policy;

    logic [IDX_W-1:0]            r_cur, n_cur;
    logic [COUNT_BITS-1:0]       r_cur_cnt, n_cur_cnt;
    logic [IDX_W-1:0]            r_before;
    logic                        r_sel_run, n_sel_run;
    logic                        r_found, n_found;
    logic [IDX_W-1:0]            r_best_idx, n_best_idx;
    logic [COUNT_BITS-1:0]       r_best_c, n_best_c;
    logic [tdts_pkg::PRIO_W-1:0] r_best_p, n_best_p;
    logic [IDX_W-1:0]            r_scan, n_scan;
    logic                        r_cmp_vld;
    logic [IDX_W-1:0]            r_cmp_idx;

    logic                        in_xfer;
    logic                        out_free;
    logic                        out_load;
    logic                        ld_ok;
    logic [COUNT_BITS-1:0]       dec_cnt;
    logic                        take;

    logic                        wr_cnt_en;
    logic                        wr_prio_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [COUNT_BITS-1:0]       wr_cnt;
    logic [COUNT_BITS-1:0]       rd_cnt;
    logic [tdts_pkg::PRIO_W-1:0] rd_prio;

    tdts_task_mem #(
        .NUM_TASKS  (NUM_TASKS),
        .COUNT_BITS (COUNT_BITS)
    ) u_task_mem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_cnt_en  (wr_cnt_en),
        .i_wr_prio_en (wr_prio_en),
        .i_wr_addr    (wr_addr),
        .i_wr_cnt     (wr_cnt),
        .i_wr_prio    (r_req.priority_value),
        .i_rd_addr    (r_scan),
        .o_rd_cnt     (rd_cnt),
        .o_rd_prio    (rd_prio)
    );

    assign o_in_ready  = (r_state == tdts_pkg::ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign ld_ok   = (r_req.task_index != '0) && (32'(r_req.task_index) < 32'(NUM_TASKS));
    assign dec_cnt = (r_cur_cnt != '0) ? r_cur_cnt - 1'b1 : '0;

    // scan compare on the entry read out last cycle
    always_comb begin
        take = 1'b0;
        if (r_cmp_vld && rd_cnt != '0) begin
            if (!r_found) begin
                take = 1'b1;
            end else if (r_policy == tdts_pkg::POLICY_SHORTEST) begin
                take = rd_cnt < r_best_c;
            end else begin
                take = rd_prio > r_best_p;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_cur_cnt  = r_cur_cnt;
        n_sel_run  = r_sel_run;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best_c   = r_best_c;
        n_best_p   = r_best_p;
        n_scan     = r_scan;
        wr_cnt_en  = 1'b0;
        wr_prio_en = 1'b0;
        wr_addr    = r_cur;
        wr_cnt     = dec_cnt;
        out_load   = 1'b0;

        if (take) begin
            n_found    = 1'b1;
            n_best_idx = r_cmp_idx;
            n_best_c   = rd_cnt;
            n_best_p   = rd_prio;
        end

        case (r_state)
            tdts_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = tdts_pkg::ST_EXEC;
                end
            end
            tdts_pkg::ST_EXEC: begin
                n_sel_run = 1'b0;
                n_found   = 1'b0;
                n_scan    = IDX_W'(1);
                case (r_req.req_type)
                    tdts_pkg::REQ_TICK: begin
                        if (r_cur == '0) begin
                            n_sel_run = 1'b1;
                        end else begin
                            wr_cnt_en = (r_cur_cnt != '0);
                            n_cur_cnt = dec_cnt;
                            n_sel_run = (dec_cnt == '0);
                        end
                    end
                    tdts_pkg::REQ_LOAD: begin
                        wr_addr    = IDX_W'(r_req.task_index);
                        wr_cnt     = COUNT_BITS'(r_req.count_value);
                        wr_cnt_en  = ld_ok;
                        wr_prio_en = ld_ok;
                        if (ld_ok && r_cur == IDX_W'(r_req.task_index)) begin
                            n_cur_cnt = COUNT_BITS'(r_req.count_value);
                        end
                    end
                    tdts_pkg::REQ_SCHED: begin
                        n_sel_run = 1'b1;
                    end
                    default: begin
                    end
                endcase
                n_state = n_sel_run ? tdts_pkg::ST_SCAN : tdts_pkg::ST_DONE;
            end
            tdts_pkg::ST_SCAN: begin
                n_scan = r_scan + 1'b1;
                if (r_scan == IDX_W'(NUM_TASKS - 1)) begin
                    n_state = tdts_pkg::ST_DRAIN;
                end
            end
            tdts_pkg::ST_DRAIN: begin
                n_state = tdts_pkg::ST_DONE;
            end
            tdts_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = tdts_pkg::ST_IDLE;
                    if (r_sel_run && r_found) begin
                        n_cur     = r_best_idx;
                        n_cur_cnt = r_best_c;
                    end
                end
            end
            default: begin
                n_state = tdts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_cur_cnt   <= '0;
            r_policy    <= tdts_pkg::POLICY_SHORTEST;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_sel_run   <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_cur     <= n_cur;
            r_cur_cnt <= n_cur_cnt;
            r_sel_run <= n_sel_run;
            r_found   <= n_found;
            r_cmp_vld <= (r_state == tdts_pkg::ST_SCAN);
            if (i_cfg_wr_en) begin
                r_policy <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req    <= i_in_data;
            r_before <= r_cur;
        end
        r_best_idx <= n_best_idx;
        r_best_c   <= n_best_c;
        r_best_p   <= n_best_p;
        r_scan     <= n_scan;
        r_cmp_idx  <= r_scan;
        if (out_load) begin
            r_out.running_task  <= tdts_pkg::TASK_W'(n_cur);
            r_out.switched      <= (n_cur != r_before);
            r_out.exhausted     <= r_sel_run && !r_found;
            r_out.running_count <= tdts_pkg::CNT_W'(n_cur_cnt);
        end
    end

    // ---------------------------------------------------------------- checks
    a_idle_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur == '0) |-> (r_cur_cnt == '0))
        else $error("idle task carries a nonzero count");

    a_switch_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.switched) |-> (o_out_data.running_task != '0))
        else $error("switch reported to the idle task");

    a_exhaust_no_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.exhausted) |-> !o_out_data.switched)
        else $error("exhausted result reports a switch");

    a_xfer_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == tdts_pkg::ST_EXEC))
        else $error("accepted request did not start execution");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the tick-driven task selector against a cycle-free scheduling
// predictor: directed cases for the empty table, tie-breaks, zero counts and
// exhaustion in shortest policy, then random load/schedule/tick sequences with
// random idling, a long output stall and drain pauses between policy changes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned NUM_TASKS   = 16;
    localparam int unsigned COUNT_BITS  = 16;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned SETTLE_CYC  = NUM_TASKS + 6;
    localparam logic [tdts_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    tdts_pkg::t_in_item  in_data;
    logic                out_valid;
    logic                out_ready;
    tdts_pkg::t_out_item out_data;
    logic                cfg_wr_en;
    logic                cfg_wr_data;

    // scheduler state as the block should hold it
    logic [tdts_pkg::CNT_W-1:0]  slot_count [NUM_TASKS];
    logic [tdts_pkg::PRIO_W-1:0] slot_prio  [NUM_TASKS];
    logic [tdts_pkg::TASK_W-1:0] run_task;
    logic                        policy_q;

    tdts_pkg::t_out_item expected_sched[$];
    tdts_pkg::t_out_item want;
    int                  err_cnt;
    int                  cycle_cnt;
    int                  rx_hold_cycles;
    bit                  burst_mode;

    tick_driven_task_selector_top #(
        .NUM_TASKS  (NUM_TASKS),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [tdts_pkg::TASK_W-1:0] pick_slot();
        logic [tdts_pkg::TASK_W-1:0] best;
        best = '0;
        for (int i = 1; i < NUM_TASKS; i++) begin
            if (slot_count[i] != 0) begin
                if (best == 0) begin
                    best = tdts_pkg::TASK_W'(i);
                end else if (policy_q == tdts_pkg::POLICY_SHORTEST) begin
                    if (slot_count[i] < slot_count[best]) best = tdts_pkg::TASK_W'(i);
                end else if (slot_prio[i] > slot_prio[best]) begin
                    best = tdts_pkg::TASK_W'(i);
                end
            end
        end
        return best;
    endfunction

    // returns 1 when nothing is runnable; the running task is then kept
    function automatic logic reselect();
        logic [tdts_pkg::TASK_W-1:0] nxt;
        nxt = pick_slot();
        if (nxt == 0) return 1'b1;
        run_task = nxt;
        return 1'b0;
    endfunction

    function automatic tdts_pkg::t_out_item predict_schedule(tdts_pkg::t_in_item it);
        tdts_pkg::t_out_item         r;
        logic [tdts_pkg::TASK_W-1:0] prev;
        logic                        exh;
        prev = run_task;
        exh  = 1'b0;
        case (it.req_type)
            tdts_pkg::REQ_TICK: begin
                if (run_task != 0 && slot_count[run_task] != 0)
                    slot_count[run_task] = slot_count[run_task] - 1'b1;
                if (run_task == 0 || slot_count[run_task] == 0)
                    exh = reselect();
            end
            tdts_pkg::REQ_LOAD: begin
                if (it.task_index != 0 && it.task_index < NUM_TASKS) begin
                    slot_count[it.task_index] = it.count_value;
                    slot_prio[it.task_index]  = it.priority_value;
                end
            end
            tdts_pkg::REQ_SCHED: begin
                exh = reselect();
            end
            default: ;
        endcase
        r.running_task  = run_task;
        r.switched      = (run_task != prev);
        r.exhausted     = exh;
        r.running_count = slot_count[run_task];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_sched.size() == 0) begin
                note_error($sformatf("unexpected result task=%0d cnt=%0d",
                                     out_data.running_task, out_data.running_count));
            end else begin
                want = expected_sched.pop_front();
                if (out_data.running_task  !== want.running_task  ||
                    out_data.switched      !== want.switched      ||
                    out_data.exhausted     !== want.exhausted     ||
                    out_data.running_count !== want.running_count) begin
                    note_error($sformatf(
                        {"exp task=%0d sw=%0b exh=%0b cnt=%0d, ",
                         "got task=%0d sw=%0b exh=%0b cnt=%0d"},
                        want.running_task, want.switched, want.exhausted,
                        want.running_count, out_data.running_task, out_data.switched,
                        out_data.exhausted, out_data.running_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_sched.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver side: random stalls, optional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready = 1'b0;
        end else if (rx_hold_cycles > 0) begin
            out_ready = 1'b0;
            rx_hold_cycles--;
        end else if (burst_mode) begin
            out_ready = 1'b1;
        end else begin
            out_ready = ($urandom_range(0, 99) >= 26);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input tdts_pkg::t_in_item it);
        @(negedge i_clk);
        while (!burst_mode && $urandom_range(0, 99) < 26) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        expected_sched.push_back(predict_schedule(it));
    endtask

    task automatic send_req(input logic [tdts_pkg::REQ_W-1:0]  req,
                            input logic [tdts_pkg::TASK_W-1:0] idx,
                            input logic [tdts_pkg::CNT_W-1:0]  cnt,
                            input logic [tdts_pkg::PRIO_W-1:0] pri);
        tdts_pkg::t_in_item it;
        it.req_type       = req;
        it.task_index     = idx;
        it.count_value    = cnt;
        it.priority_value = pri;
        send_item(it);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (expected_sched.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_policy(input logic pol);
        wait_idle();
        @(negedge i_clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = pol;
        @(negedge i_clk);
        cfg_wr_en   = 1'b0;
        policy_q    = pol;
    endtask

    function automatic logic [tdts_pkg::CNT_W-1:0] rand_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return tdts_pkg::CNT_W'($urandom_range(0, 5));
        if (roll < 85) return tdts_pkg::CNT_W'($urandom_range(0, 40));
        return tdts_pkg::CNT_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [tdts_pkg::PRIO_W-1:0] rand_prio();
        if ($urandom_range(0, 1) == 0) return tdts_pkg::PRIO_W'($urandom_range(0, 3));
        return tdts_pkg::PRIO_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [tdts_pkg::TASK_W-1:0] rand_idx();
        return tdts_pkg::TASK_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [tdts_pkg::CNT_W-1:0] rand_word();
        return tdts_pkg::CNT_W'($urandom_range(0, 65535));
    endfunction

    // mostly load / schedule / tick runs; the rest is random noise
    task automatic run_sequence(inout int sent);
        logic [tdts_pkg::TASK_W-1:0] idx;
        logic [tdts_pkg::REQ_W-1:0]  req;
        int                          n;
        if ($urandom_range(0, 99) < 80) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                idx = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
                send_req(tdts_pkg::REQ_LOAD, idx, rand_count(), rand_prio());
                if (idx != 0) sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                send_req(tdts_pkg::REQ_SCHED, rand_idx(), rand_word(), rand_word());
                sent++;
            end
            n = $urandom_range(1, 12);
            repeat (n) begin
                send_req(tdts_pkg::REQ_TICK, rand_idx(), rand_word(), rand_word());
                sent++;
            end
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                req = tdts_pkg::REQ_W'($urandom_range(0, 3));
                idx = rand_idx();
                send_req(req, idx, rand_word(), rand_word());
                if (req != REQ_UNUSED && !(req == tdts_pkg::REQ_LOAD && idx == 0)) sent++;
            end
        end
        // occasional full drain with the sender paused
        if ($urandom_range(0, 149) == 0) wait_idle();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_table();
        send_req(tdts_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);
        send_req(tdts_pkg::REQ_SCHED, 4'd0, 16'd0, 16'd0);
        send_req(REQ_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF);
        // the idle slot never takes a load
        send_req(tdts_pkg::REQ_LOAD, 4'd0, 16'hFFFF, 16'hFFFF);
        send_req(tdts_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);
    endtask

    task automatic test_shortest_directed();
        set_policy(tdts_pkg::POLICY_SHORTEST);
        send_req(tdts_pkg::REQ_LOAD, 4'd15, 16'hFFFF, 16'hFFFF);
        send_req(tdts_pkg::REQ_LOAD, 4'd10, 16'd1, 16'd0);
        send_req(tdts_pkg::REQ_LOAD, 4'd5, 16'd1, 16'h5555);
        send_req(tdts_pkg::REQ_SCHED, 4'd0, 16'd0, 16'd0);     // tie on count, slot 5
        send_req(tdts_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);      // slot 5 runs out
        send_req(tdts_pkg::REQ_SCHED, 4'd0, 16'd0, 16'd0);     // reselect with count left
        send_req(tdts_pkg::REQ_LOAD, 4'd10, 16'd0, 16'hAAAA);  // zero the running slot
        send_req(tdts_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);      // tick at zero count
        send_req(tdts_pkg::REQ_LOAD, 4'd15, 16'd0, 16'd0);
        send_req(tdts_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);      // exhausted, task kept
        send_req(REQ_UNUSED, 4'd0, 16'd0, 16'd0);
    endtask

    task automatic test_priority_directed();
        set_policy(tdts_pkg::POLICY_PRIORITY);
        send_req(tdts_pkg::REQ_LOAD, 4'd3, 16'd7, 16'd100);
        send_req(tdts_pkg::REQ_LOAD, 4'd12, 16'd2, 16'd100);
        send_req(tdts_pkg::REQ_LOAD, 4'd9, 16'd0, 16'hFFFF);   // top priority but no count
        send_req(tdts_pkg::REQ_SCHED, 4'd0, 16'd0, 16'd0);     // tie on priority, slot 3
        send_req(tdts_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);
        send_req(tdts_pkg::REQ_LOAD, 4'd3, 16'd0, 16'd100);
        send_req(tdts_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);
    endtask

    task automatic test_random(input int n_items, input logic pol, input bit burst);
        int sent;
        set_policy(pol);
        burst_mode = burst;
        sent = 0;
        while (sent < n_items) run_sequence(sent);
        burst_mode = 1'b0;
    endtask

    task automatic test_output_stall(input int n_items);
        int sent;
        wait_idle();
        @(posedge i_clk);
        rx_hold_cycles = 300;
        sent = 0;
        while (sent < n_items) run_sequence(sent);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        err_cnt        = 0;
        cycle_cnt      = 0;
        rx_hold_cycles = 0;
        burst_mode     = 1'b0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            slot_count[i] = '0;
            slot_prio[i]  = '0;
        end
        run_task = '0;
        policy_q = tdts_pkg::POLICY_SHORTEST;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_shortest_directed();
        test_priority_directed();
        test_random(600, tdts_pkg::POLICY_SHORTEST, 1'b0);
        test_random(500, tdts_pkg::POLICY_PRIORITY, 1'b0);
        test_random(300, tdts_pkg::POLICY_SHORTEST, 1'b1);
        test_output_stall(100);
        test_random(500, tdts_pkg::POLICY_PRIORITY, 1'b0);
        test_random(100, tdts_pkg::POLICY_SHORTEST, 1'b0);
        wait_idle();

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
design/tdts_pkg.sv
design/tdts_task_mem.sv
design/tick_driven_task_selector_top.sv
test/tb_top.sv
